// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/vna_pkg.sv =====
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int IDX_W  = 10;
    localparam int FLD_W  = 24;
    localparam int ACC_W  = 56;
    localparam int MUL_W  = 31;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = 62;
    localparam int Q_W    = 16;

    // Operation codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
        logic [IDX_W-1:0]        index_c;
        logic signed [FLD_W-1:0] pos_x;
        logic signed [FLD_W-1:0] pos_y;
        logic signed [FLD_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0]      vertex_id;
        logic signed [Q_W-1:0] norm_x;
        logic signed [Q_W-1:0] norm_y;
        logic signed [Q_W-1:0] norm_z;
        logic                  zero_normal;
    } t_out;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_T_RDA,
        S_T_RDB,
        S_T_RDC,
        S_T_EDGE,
        S_T_MUL,
        S_T_MACC,
        S_T_ARD,
        S_T_AWR,
        S_R_RD,
        S_R_CHK,
        S_R_SHIFT,
        S_R_SQ,
        S_R_SQACC,
        S_R_QSTART,
        S_R_QWAIT,
        S_R_DONE
    } t_state;

endpackage

// ===== rtl/vertex_normal_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_accumulate_core
// Area-weighted smooth vertex normals: load positions, accumulate triangle
// cross products, read back unit normals in Q1.15.
// ----------------------------------------------------------------------------
//  channel  | signals                      | role
//  ---------+------------------------------+---------------------------------
//  input    | i_valid, o_ready, i_data     | load / triangle / read commands
//  output   | o_valid, i_ready, o_data     | one normal per read command
//
//  Load: written on acceptance, also clearing the vertex's accumulator.
//  Triangle: busy after the transfer for three position reads, edge setup,
//  six products on the shared multiplier and three accumulator
//  read-modify-writes. Read: busy for up to 26 single-bit shifts, three
//  squares and three bit-serial quotient solves; a zero accumulator skips
//  them. After reset the accumulator RAM is swept to zero with o_ready low.
//  A stalled result sits in the output register; a later read waits in its
//  final state until that register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertex_normal_accumulate_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int POS_BITS     = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  vna_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output vna_pkg::t_out o_data
);
    import vna_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int PB = (POS_BITS < FLD_W) ? POS_BITS : FLD_W;
    localparam logic [AW-1:0] LAST = AW'(MAX_VERTICES - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    t_state r_state, n_state;

    logic [AW-1:0]  r_clr;
    logic [IDX_W-1:0] r_ia, r_ib, r_ic;
    logic [3*PB-1:0] r_pa, r_pb;
    logic signed [PB:0] r_e1 [3];
    logic signed [PB:0] r_e2 [3];
    logic signed [ACC_W-1:0] r_n [3];
    logic [2:0]     r_step;
    logic [1:0]     r_cnt;
    logic [ACC_W-1:0] r_m [3];
    logic [2:0]     r_sgn;
    logic [SQ_W-1:0] r_r2 [3];
    logic [SUM_W-1:0] r_s;
    t_out           r_res;
    t_out           r_out;
    logic           r_out_valid;

    logic accept, in_a_ok, tri_ok, out_free;
    logic pos_we, acc_we;
    logic [AW-1:0] pos_raddr, acc_waddr, acc_raddr, corner;
    logic [3*PB-1:0] pos_wdata, pos_rdata;
    logic [3*ACC_W-1:0] acc_wdata, acc_rdata, acc_sum;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic q_start, q_done;
    logic [Q_W-1:0] q_val;
    logic [1:0] ma_idx, mb_idx;
    logic signed [Q_W-1:0] q_signed;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign in_a_ok  = 32'(i_data.index_a) < 32'(MAX_VERTICES);
    assign tri_ok   = in_a_ok && (32'(i_data.index_b) < 32'(MAX_VERTICES))
                      && (32'(i_data.index_c) < 32'(MAX_VERTICES));
    assign out_free = !r_out_valid || i_ready;

    // memories
    vna_ram #(.WIDTH(3*PB), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (AW'(i_data.index_a)),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(3*ACC_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    vna_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    vna_qsolve u_qsolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_r2    (r_r2[r_cnt]),
        .i_s     (r_s),
        .o_done  (q_done),
        .o_q     (q_val)
    );

    assign pos_we    = accept && (i_data.opcode == OP_LOAD) && in_a_ok;
    assign pos_wdata = {i_data.pos_z[PB-1:0], i_data.pos_y[PB-1:0], i_data.pos_x[PB-1:0]};

    // triangle corner for the accumulator read-modify-write
    always_comb begin
        case (r_cnt)
            2'd0:    corner = AW'(r_ia);
            2'd1:    corner = AW'(r_ib);
            default: corner = AW'(r_ic);
        endcase
    end

    // position read address
    always_comb begin
        case (r_state)
            S_T_RDB: pos_raddr = AW'(r_ib);
            S_T_RDC: pos_raddr = AW'(r_ic);
            default: pos_raddr = AW'(r_ia);
        endcase
    end

    assign acc_raddr = (r_state == S_T_ARD) ? corner : AW'(r_ia);

    // saturating add of the cross product to each component
    always_comb begin
        logic signed [ACC_W:0] s;
        logic signed [ACC_W-1:0] a;
        for (int i = 0; i < 3; i++) begin
            a = acc_rdata[i*ACC_W +: ACC_W];
            s = {a[ACC_W-1], a} + {r_n[i][ACC_W-1], r_n[i]};
            if (s[ACC_W] != s[ACC_W-1]) begin
                acc_sum[i*ACC_W +: ACC_W] = s[ACC_W] ? ACC_MIN : ACC_MAX;
            end else begin
                acc_sum[i*ACC_W +: ACC_W] = s[ACC_W-1:0];
            end
        end
    end

    // accumulator write: clearing sweep, load clear, triangle update
    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = AW'(i_data.index_a);
        acc_wdata = '0;
        if (r_state == S_CLEAR) begin
            acc_we    = 1'b1;
            acc_waddr = r_clr;
        end else if (pos_we) begin
            acc_we    = 1'b1;
        end else if (r_state == S_T_AWR) begin
            acc_we    = 1'b1;
            acc_waddr = corner;
            acc_wdata = acc_sum;
        end
    end

    // multiplier operand select: cross product terms, then squares
    always_comb begin
        case (r_step)
            3'd0:    begin ma_idx = 2'd1; mb_idx = 2'd2; end
            3'd1:    begin ma_idx = 2'd2; mb_idx = 2'd1; end
            3'd2:    begin ma_idx = 2'd2; mb_idx = 2'd0; end
            3'd3:    begin ma_idx = 2'd0; mb_idx = 2'd2; end
            3'd4:    begin ma_idx = 2'd0; mb_idx = 2'd1; end
            default: begin ma_idx = 2'd1; mb_idx = 2'd0; end
        endcase
        if (r_state == S_R_SQ) begin
            mul_a = {1'b0, r_m[r_cnt][MAG_W-1:0]};
            mul_b = {1'b0, r_m[r_cnt][MAG_W-1:0]};
        end else begin
            mul_a = {{(MUL_W-PB-1){r_e1[ma_idx][PB]}}, r_e1[ma_idx]};
            mul_b = {{(MUL_W-PB-1){r_e2[mb_idx][PB]}}, r_e2[mb_idx]};
        end
    end

    assign q_start = (r_state == S_R_QSTART);

    // apply sign; plus one saturates, minus one stays
    always_comb begin
        if (r_sgn[r_cnt]) begin
            q_signed = -$signed(q_val);
        end else if (q_val[Q_W-1]) begin
            q_signed = {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            q_signed = $signed(q_val);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr == LAST) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    if (i_data.opcode == OP_TRI && tri_ok) begin
                        n_state = S_T_RDA;
                    end else if (i_data.opcode == OP_READ) begin
                        n_state = in_a_ok ? S_R_RD : S_R_DONE;
                    end
                end
            end
            S_T_RDA:    n_state = S_T_RDB;
            S_T_RDB:    n_state = S_T_RDC;
            S_T_RDC:    n_state = S_T_EDGE;
            S_T_EDGE:   n_state = S_T_MUL;
            S_T_MUL:    n_state = S_T_MACC;
            S_T_MACC:   n_state = (r_step == 3'd5) ? S_T_ARD : S_T_MUL;
            S_T_ARD:    n_state = S_T_AWR;
            S_T_AWR:    n_state = (r_cnt == 2'd2) ? S_IDLE : S_T_ARD;
            S_R_RD:     n_state = S_R_CHK;
            S_R_CHK:    n_state = (acc_rdata == '0) ? S_R_DONE : S_R_SHIFT;
            S_R_SHIFT: begin
                if (!(|r_m[0][ACC_W-1:MAG_W] || |r_m[1][ACC_W-1:MAG_W]
                      || |r_m[2][ACC_W-1:MAG_W])) begin
                    n_state = S_R_SQ;
                end
            end
            S_R_SQ:     n_state = S_R_SQACC;
            S_R_SQACC:  n_state = (r_cnt == 2'd2) ? S_R_QSTART : S_R_SQ;
            S_R_QSTART: n_state = S_R_QWAIT;
            S_R_QWAIT: begin
                if (q_done) n_state = (r_cnt == 2'd2) ? S_R_DONE : S_R_QSTART;
            end
            S_R_DONE:   if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ia  <= i_data.index_a;
                r_ib  <= i_data.index_b;
                r_ic  <= i_data.index_c;
                r_step <= '0;
                r_cnt  <= '0;
                r_res  <= '{vertex_id: i_data.index_a, norm_x: '0, norm_y: '0,
                            norm_z: '0, zero_normal: 1'b1};
            end
            S_T_RDB:  r_pa <= pos_rdata;
            S_T_RDC:  r_pb <= pos_rdata;
            S_T_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    r_e1[i] <= $signed({r_pb[i*PB+PB-1], r_pb[i*PB +: PB]})
                             - $signed({r_pa[i*PB+PB-1], r_pa[i*PB +: PB]});
                    r_e2[i] <= $signed({pos_rdata[i*PB+PB-1], pos_rdata[i*PB +: PB]})
                             - $signed({r_pa[i*PB+PB-1], r_pa[i*PB +: PB]});
                end
            end
            S_T_MACC: begin
                if (r_step[0]) begin
                    r_n[r_step[2:1]] <= r_n[r_step[2:1]] - mul_p[ACC_W-1:0];
                end else begin
                    r_n[r_step[2:1]] <= mul_p[ACC_W-1:0];
                end
                r_step <= r_step + 3'd1;
            end
            S_T_AWR:  r_cnt <= r_cnt + 2'd1;
            S_R_CHK: begin
                for (int i = 0; i < 3; i++) begin
                    r_sgn[i] <= acc_rdata[i*ACC_W + ACC_W - 1];
                    r_m[i]   <= acc_rdata[i*ACC_W + ACC_W - 1]
                                ? (~acc_rdata[i*ACC_W +: ACC_W] + ACC_W'(1))
                                : acc_rdata[i*ACC_W +: ACC_W];
                end
                r_res.zero_normal <= (acc_rdata == '0);
                r_s <= '0;
            end
            S_R_SHIFT: begin
                if (|r_m[0][ACC_W-1:MAG_W] || |r_m[1][ACC_W-1:MAG_W]
                    || |r_m[2][ACC_W-1:MAG_W]) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end
            end
            S_R_SQACC: begin
                r_r2[r_cnt] <= mul_p[SQ_W-1:0];
                r_s         <= r_s + SUM_W'(mul_p[SQ_W-1:0]);
                r_cnt       <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 2'd1;
            end
            S_R_QWAIT: begin
                if (q_done) begin
                    case (r_cnt)
                        2'd0:    r_res.norm_x <= q_signed;
                        2'd1:    r_res.norm_y <= q_signed;
                        default: r_res.norm_z <= q_signed;
                    endcase
                    r_cnt <= r_cnt + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_R_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_R_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    `ASSERT_IMPLY(a_clear_not_ready, i_clk, i_rst_n, r_state == S_CLEAR, !o_ready)
    `ASSERT_IMPLY(a_done_in_wait, i_clk, i_rst_n, q_done, r_state == S_R_QWAIT)
    `ASSERT_IMPLY(a_zero_flag, i_clk, i_rst_n, o_valid && o_data.zero_normal, o_data.norm_x == '0 && o_data.norm_y == '0 && o_data.norm_z == '0)
    `ASSERT_NEXT(a_tri_start, i_clk, i_rst_n, accept && i_data.opcode == OP_TRI && tri_ok, r_state == S_T_RDA)

endmodule

// ===== rtl/vna_ram.sv =====
// ----------------------------------------------------------------------------
// vna_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vna_mul.sv =====
// ----------------------------------------------------------------------------
// vna_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vna_mul (
    input  logic                               i_clk,
    input  logic signed [vna_pkg::MUL_W-1:0]   i_a,
    input  logic signed [vna_pkg::MUL_W-1:0]   i_b,
    output logic signed [vna_pkg::PROD_W-1:0]  o_p
);
    import vna_pkg::*;

    logic signed [PROD_W-1:0] r_p;

    // one product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/vna_qsolve.sv =====
// ----------------------------------------------------------------------------
// vna_qsolve
// Bit-serial solver: largest q with q*q*S <= r2 * 2^30, one bit
// at a time, using incremental squares instead of multiplies.
// ----------------------------------------------------------------------------
module vna_qsolve (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vna_pkg::SQ_W-1:0]   i_r2,
    input  logic [vna_pkg::SUM_W-1:0]  i_s,
    output logic                       o_done,
    output logic [vna_pkg::Q_W-1:0]    o_q
);
    import vna_pkg::*;

    localparam int W = 96;

    logic            r_busy;
    logic            r_phase;
    logic            r_done;
    logic [3:0]      r_bit;
    logic [W-1:0]    r_p;     // q*q*S so far
    logic [W-1:0]    r_qs;    // q*S shifted left by bit+1
    logic [W-1:0]    r_sb;    // S shifted left by 2*bit
    logic [W-1:0]    r_r;     // r2 shifted left by 30
    logic [W-1:0]    r_t;
    logic [Q_W-1:0]  r_q;
    logic [W-1:0]    cand;

    assign cand = r_t + r_sb;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_bit   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_bit   <= 4'd15;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    if (r_bit == 4'd0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_bit <= r_bit - 4'd1;
                    end
                end
            end
        end
    end

    // datapath: phase 0 adds P + Qs, phase 1 adds Sb and tests
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p  <= '0;
            r_qs <= '0;
            r_sb <= W'(i_s) << 30;
            r_r  <= W'(i_r2) << 30;
            r_q  <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_t <= r_p + r_qs;
            end else begin
                if (cand <= r_r) begin
                    r_p  <= cand;
                    r_qs <= (r_qs >> 1) + r_sb;
                    r_q  <= r_q | (Q_W'(1) << r_bit);
                end else begin
                    r_qs <= r_qs >> 1;
                end
                r_sb <= r_sb >> 2;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule
